FILE: sv/ws2812_frame_encoder_defines.svh
// Assertion macros shared by the encoder checker.
`ifndef WS2812_FRAME_ENCODER_DEFINES_SVH
`define WS2812_FRAME_ENCODER_DEFINES_SVH

// Condition holds on the same edge as the trigger.
`define WFE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Condition holds on the edge after the trigger.
`define WFE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/wfe_pkg.sv
// Types, constants and the brightness table of the WS2812 frame encoder.
package wfe_pkg;

    typedef enum logic [1:0] {
        REQ_SET_ONE = 2'd0,
        REQ_APPLY   = 2'd1,
        REQ_SLOT    = 2'd2,
        REQ_SET_ALL = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        REG_BRIGHTNESS  = 2'd0,
        REG_ONE_DUTY    = 2'd1,
        REG_ZERO_DUTY   = 2'd2,
        REG_LATCH_SLOTS = 2'd3
    } reg_idx_t;

    localparam int          BITS_PER_LED = 24;
    localparam logic [4:0]  BIT_LAST     = 5'(BITS_PER_LED - 1);
    localparam logic [5:0]  MAX_ANGLE    = 6'd45;
    localparam logic [5:0]  BRIGHT_RST   = 6'd45;
    localparam logic [7:0]  ONE_DUTY_RST = 8'd60;
    localparam logic [7:0]  ZERO_DUTY_RST = 8'd30;
    localparam logic [7:0]  LATCH_RST    = 8'd50;

    // round(tan(deg) * 65536) for 0..45 degrees
    function automatic logic [16:0] tan_q16(input logic [5:0] deg);
        logic [16:0] t;
        unique case (deg)
            6'd0:  t = 17'd0;
            6'd1:  t = 17'd1144;
            6'd2:  t = 17'd2289;
            6'd3:  t = 17'd3435;
            6'd4:  t = 17'd4583;
            6'd5:  t = 17'd5734;
            6'd6:  t = 17'd6888;
            6'd7:  t = 17'd8047;
            6'd8:  t = 17'd9210;
            6'd9:  t = 17'd10380;
            6'd10: t = 17'd11556;
            6'd11: t = 17'd12739;
            6'd12: t = 17'd13930;
            6'd13: t = 17'd15130;
            6'd14: t = 17'd16340;
            6'd15: t = 17'd17560;
            6'd16: t = 17'd18792;
            6'd17: t = 17'd20036;
            6'd18: t = 17'd21294;
            6'd19: t = 17'd22566;
            6'd20: t = 17'd23853;
            6'd21: t = 17'd25157;
            6'd22: t = 17'd26478;
            6'd23: t = 17'd27818;
            6'd24: t = 17'd29179;
            6'd25: t = 17'd30560;
            6'd26: t = 17'd31964;
            6'd27: t = 17'd33392;
            6'd28: t = 17'd34846;
            6'd29: t = 17'd36327;
            6'd30: t = 17'd37837;
            6'd31: t = 17'd39378;
            6'd32: t = 17'd40951;
            6'd33: t = 17'd42560;
            6'd34: t = 17'd44205;
            6'd35: t = 17'd45889;
            6'd36: t = 17'd47615;
            6'd37: t = 17'd49385;
            6'd38: t = 17'd51202;
            6'd39: t = 17'd53070;
            6'd40: t = 17'd54991;
            6'd41: t = 17'd56970;
            6'd42: t = 17'd59009;
            6'd43: t = 17'd61113;
            6'd44: t = 17'd63287;
            default: t = 17'd65536;
        endcase
        return t;
    endfunction

endpackage

FILE: sv/wfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 12
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/ws2812_frame_encoder.sv
// WS2812 frame encoder: colour store, brightness scaler and PWM slot stream.
//
//  channel  dir  tdata                                   tuser / tlast
//  s_       in   [3:0] led_index [11:4] red [19:12] green  tuser[1:0] req_type
//                [27:20] blue, [31:28] zero
//  m_       out  [7:0] duty                              tlast = frame_last
//  cfg_     in   cfg_index 0..3, cfg_data[7:0]           write on cfg_wr_en
//
// Set one LED is written straight from idle, set all LEDs sweeps every LED,
// apply brightness sweeps every LED (per LED: one RAM read, three passes
// through the shared 8x17 multiplier, one RAM write), and next slot reads the
// scaled RAM read port before it emits. After reset a clearing pass zeroes
// both colour RAMs; s_tready stays low meanwhile. A slot waits in the emit
// step while the output register is full and m_tready is low.
module ws2812_frame_encoder #(
    parameter int NUM_LEDS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // led_index, red, green, blue, zero fill
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // duty
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import wfe_pkg::*;

    localparam int             LED_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [LED_W-1:0] LAST_LED = LED_W'(NUM_LEDS - 1);
    localparam logic [8:0]     NUM_LEDS_9 = 9'(NUM_LEDS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET_ALL,
        ST_A_RD,
        ST_A_MUL,
        ST_A_WR,
        ST_S_RD,
        ST_S_EMIT
    } state_t;

    state_t             state_reg;
    logic [LED_W-1:0]   sweep_reg;
    logic [1:0]         mul_cnt_reg;
    logic [16:0]        factor_reg;
    logic [23:0]        acc_reg;
    logic [23:0]        colour_reg;
    logic [LED_W-1:0]   led_cnt_reg;
    logic [4:0]         bit_cnt_reg;
    logic               in_latch_reg;
    logic [7:0]         lat_cnt_reg;
    logic               m_valid_reg;
    logic [7:0]         duty_reg;
    logic               last_reg;
    logic [5:0]         brightness_reg;
    logic [7:0]         one_duty_reg;
    logic [7:0]         zero_duty_reg;
    logic [7:0]         latch_slots_reg;

    logic [3:0]  in_led;
    logic [23:0] in_colour;
    req_t        in_req;
    logic        accept;

    logic               raw_we, scl_we, raw_re, scl_re;
    logic [LED_W-1:0]   raw_waddr, scl_waddr, raw_raddr, scl_raddr;
    logic [23:0]        raw_wdata, scl_wdata, raw_rdata, scl_rdata;

    logic [7:0]  byte_sel;
    logic [24:0] prod;
    logic        emit_go;
    logic        slot_bit;
    logic        slot_last;

    assign in_req    = req_t'(s_tuser);
    assign in_led    = s_tdata[3:0];
    // pack as G, R, B
    assign in_colour = {s_tdata[19:12], s_tdata[11:4], s_tdata[27:20]};
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    // RAM port steering
    always_comb begin
        raw_we    = 1'b0;
        raw_waddr = sweep_reg;
        raw_wdata = colour_reg;
        scl_we    = 1'b0;
        scl_waddr = sweep_reg;
        scl_wdata = acc_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                raw_we    = 1'b1;
                raw_wdata = '0;
                scl_we    = 1'b1;
                scl_wdata = '0;
            end
            ST_IDLE: begin
                raw_we    = accept && (in_req == REQ_SET_ONE) &&
                            ({5'd0, in_led} < NUM_LEDS_9);
                raw_waddr = LED_W'(in_led);
                raw_wdata = in_colour;
            end
            ST_SET_ALL: raw_we = 1'b1;
            ST_A_WR:    scl_we = 1'b1;
            default: ;
        endcase
    end

    assign raw_re    = (state_reg == ST_A_RD);
    assign raw_raddr = sweep_reg;
    assign scl_re    = (state_reg == ST_S_RD);
    assign scl_raddr = led_cnt_reg;

    wfe_ram #(.WIDTH(24), .DEPTH(NUM_LEDS)) u_raw_ram (
        .aclk  (aclk),
        .we    (raw_we),
        .waddr (raw_waddr),
        .wdata (raw_wdata),
        .re    (raw_re),
        .raddr (raw_raddr),
        .rdata (raw_rdata)
    );

    wfe_ram #(.WIDTH(24), .DEPTH(NUM_LEDS)) u_scl_ram (
        .aclk  (aclk),
        .we    (scl_we),
        .waddr (scl_waddr),
        .wdata (scl_wdata),
        .re    (scl_re),
        .raddr (scl_raddr),
        .rdata (scl_rdata)
    );

    // Shared scaler: one byte per cycle, G then R then B
    always_comb begin
        unique case (mul_cnt_reg)
            2'd0:    byte_sel = raw_rdata[23:16];
            2'd1:    byte_sel = raw_rdata[15:8];
            default: byte_sel = raw_rdata[7:0];
        endcase
    end

    assign prod = 25'(byte_sel) * 25'(factor_reg);

    // Slot decode
    assign emit_go  = !m_valid_reg || m_tready;
    assign slot_bit = scl_rdata[BIT_LAST - bit_cnt_reg];
    always_comb begin
        if (in_latch_reg) begin
            slot_last = (9'(lat_cnt_reg) + 9'd1) >= 9'(latch_slots_reg);
        end else begin
            slot_last = (latch_slots_reg == 8'd0) && (led_cnt_reg == LAST_LED) &&
                        (bit_cnt_reg == BIT_LAST);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            sweep_reg       <= '0;
            mul_cnt_reg     <= '0;
            led_cnt_reg     <= '0;
            bit_cnt_reg     <= '0;
            in_latch_reg    <= 1'b0;
            lat_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
            brightness_reg  <= BRIGHT_RST;
            one_duty_reg    <= ONE_DUTY_RST;
            zero_duty_reg   <= ZERO_DUTY_RST;
            latch_slots_reg <= LATCH_RST;
        end else begin
            if (cfg_wr_en) begin
                unique case (reg_idx_t'(cfg_index))
                    REG_BRIGHTNESS:  brightness_reg  <= (cfg_data[5:0] > MAX_ANGLE) ?
                                                        MAX_ANGLE : cfg_data[5:0];
                    REG_ONE_DUTY:    one_duty_reg    <= cfg_data;
                    REG_ZERO_DUTY:   zero_duty_reg   <= cfg_data;
                    REG_LATCH_SLOTS: latch_slots_reg <= cfg_data;
                endcase
            end

            // drop the word once taken, unless a new one replaces it
            if (m_valid_reg && m_tready && !((state_reg == ST_S_EMIT) && emit_go)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    if (sweep_reg == LAST_LED) begin
                        sweep_reg <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        sweep_reg <= sweep_reg + LED_W'(1);
                    end
                end
                ST_IDLE: begin
                    sweep_reg <= '0;
                    if (accept) begin
                        unique case (in_req)
                            REQ_SET_ONE: ;
                            REQ_SET_ALL: begin
                                colour_reg <= in_colour;
                                state_reg  <= ST_SET_ALL;
                            end
                            REQ_APPLY: begin
                                factor_reg <= tan_q16(brightness_reg);
                                state_reg  <= ST_A_RD;
                            end
                            REQ_SLOT: state_reg <= ST_S_RD;
                        endcase
                    end
                end
                ST_SET_ALL: begin
                    if (sweep_reg == LAST_LED) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        sweep_reg <= sweep_reg + LED_W'(1);
                    end
                end
                ST_A_RD: begin
                    mul_cnt_reg <= '0;
                    state_reg   <= ST_A_MUL;
                end
                ST_A_MUL: begin
                    // floor(byte * factor / 65536)
                    acc_reg <= {acc_reg[15:0], prod[23:16]};
                    if (mul_cnt_reg == 2'd2) begin
                        state_reg <= ST_A_WR;
                    end else begin
                        mul_cnt_reg <= mul_cnt_reg + 2'd1;
                    end
                end
                ST_A_WR: begin
                    if (sweep_reg == LAST_LED) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        sweep_reg <= sweep_reg + LED_W'(1);
                        state_reg <= ST_A_RD;
                    end
                end
                ST_S_RD: state_reg <= ST_S_EMIT;
                ST_S_EMIT: begin
                    // hold until the output register frees up
                    if (emit_go) begin
                        m_valid_reg <= 1'b1;
                        last_reg    <= slot_last;
                        if (in_latch_reg) begin
                            duty_reg <= 8'd0;
                        end else begin
                            duty_reg <= slot_bit ? one_duty_reg : zero_duty_reg;
                        end
                        if (slot_last) begin
                            led_cnt_reg  <= '0;
                            bit_cnt_reg  <= '0;
                            in_latch_reg <= 1'b0;
                            lat_cnt_reg  <= '0;
                        end else if (in_latch_reg) begin
                            lat_cnt_reg <= lat_cnt_reg + 8'd1;
                        end else if (bit_cnt_reg == BIT_LAST) begin
                            bit_cnt_reg <= '0;
                            if (led_cnt_reg == LAST_LED) begin
                                in_latch_reg <= 1'b1;
                                lat_cnt_reg  <= '0;
                            end else begin
                                led_cnt_reg <= led_cnt_reg + LED_W'(1);
                            end
                        end else begin
                            bit_cnt_reg <= bit_cnt_reg + 5'd1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = duty_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: sv/wfe_checker.sv
// Port-level checker for the WS2812 frame encoder, bound to the top level.
`include "ws2812_frame_encoder_defines.svh"

module wfe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);
    import wfe_pkg::*;

    logic        out_stall;
    logic [9:0]  out_word;
    logic        slot_take;

    assign out_stall = m_tvalid && !m_tready;
    assign out_word  = {m_tvalid, m_tdata, m_tlast};
    assign slot_take = s_tvalid && s_tready && (s_tuser == REQ_SLOT);

    // stalled word holds
    `WFE_ASSERT_NXT(a_out_hold, out_stall, $stable(out_word), "stalled word changed")

    // a slot request keeps the block busy through its RAM read
    `WFE_ASSERT_NXT(a_slot_busy, slot_take, !s_tready, "input taken during slot fetch")

    // clearing pass runs right after reset
    `WFE_ASSERT_IMP(a_clear_busy, $rose(aresetn), !s_tready, "input ready during clear")

    // a word is only produced while the block is busy
    `WFE_ASSERT_IMP(a_word_src, $rose(m_tvalid), $past(!s_tready), "output word while idle")

endmodule

bind ws2812_frame_encoder wfe_checker u_wfe_checker (.*);

FILE: tb/sv/tb_ws2812_frame_encoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for ws2812_frame_encoder: directed table, then random phases.
module tb_ws2812_frame_encoder;
    import wfe_pkg::*;

    localparam int LEDS       = 12;
    localparam int DATA_SLOTS = LEDS * BITS_PER_LED;
    localparam int IDLE_PCT   = 29;
    localparam int SETTLE     = 5 * LEDS + 30;
    localparam int LIMIT      = 400000;

    typedef struct packed {
        logic [7:0] duty;
        logic       last;
    } slot_t;

    typedef struct packed {
        req_t       req;
        logic [3:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       typed;
        logic [7:0] duty;
        logic       last;
    } row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // led_index, red, green, blue, zero fill
    logic [1:0]  s_tuser   = REQ_SET_ONE; // req_type
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // duty
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_BRIGHTNESS;
    logic [7:0]  cfg_data  = '0;

    ws2812_frame_encoder #(.NUM_LEDS(LEDS)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Q16 gain per brightness angle: round(tan(deg) * 65536)
    int unsigned angle_gain [46] = '{
        0, 1144, 2289, 3435, 4583, 5734, 6888, 8047, 9210, 10380,
        11556, 12739, 13930, 15130, 16340, 17560, 18792, 20036, 21294, 22566,
        23853, 25157, 26478, 27818, 29179, 30560, 31964, 33392, 34846, 36327,
        37837, 39378, 40951, 42560, 44205, 45889, 47615, 49385, 51202, 53070,
        54991, 56970, 59009, 61113, 63287, 65536
    };

    // Predicted strip state and register copy
    logic [23:0] raw_grb [LEDS] = '{default: '0};
    logic [23:0] lit_grb [LEDS] = '{default: '0};
    int          slot_pos       = 0;
    logic [5:0]  bright_reg     = BRIGHT_RST;
    logic [7:0]  one_reg        = ONE_DUTY_RST;
    logic [7:0]  zero_reg       = ZERO_DUTY_RST;
    logic [7:0]  latch_reg      = LATCH_RST;

    slot_t pending_slots [$];
    int    mismatches = 0;
    int    cycles     = 0;
    bit    idle_on    = 1'b1;

    row_t script [25] = '{
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b1, ZERO_DUTY_RST, 1'b0},
        '{REQ_SET_ONE, 4'd0,  8'hFF, 8'hFF, 8'hFF, 1'b0, 8'd0, 1'b0},
        '{REQ_SET_ONE, 4'd11, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SET_ONE, 4'd15, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'd0, 1'b0},
        '{REQ_SET_ONE, 4'd12, 8'hAA, 8'h55, 8'hAA, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b1, ZERO_DUTY_RST, 1'b0},
        '{REQ_APPLY,   4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b1, ONE_DUTY_RST, 1'b0},
        '{REQ_SET_ALL, 4'd7,  8'h96, 8'h69, 8'h0F, 1'b0, 8'd0, 1'b0},
        '{REQ_SET_ONE, 4'd1,  8'h01, 8'h80, 8'hFE, 1'b0, 8'd0, 1'b0},
        '{REQ_APPLY,   4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SET_ALL, 4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_APPLY,   4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0},
        '{REQ_SLOT,    4'd0,  8'h00, 8'h00, 8'h00, 1'b1, ZERO_DUTY_RST, 1'b0}
    };

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb_ws2812_frame_encoder NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: %s mismatch, got %0d want %0d", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : watch_slots
        slot_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_slots.size() == 0) begin
                flag_mismatch("unexpected word", m_tdata, -1);
            end else begin
                want = pending_slots.pop_front();
                if (m_tdata !== want.duty)
                    flag_mismatch("duty", m_tdata, want.duty);
                if (m_tlast !== want.last)
                    flag_mismatch("frame_last", m_tlast, want.last);
            end
        end
    end

    function automatic logic [7:0] dim(input logic [7:0] v, input int unsigned gain);
        return 8'((v * gain) >> 16);
    endfunction

    // Update the strip model for one accepted word; a slot request yields one slot.
    task automatic advance_strip(input req_t req, input logic [3:0] idx,
                                 input logic [7:0] red, green, blue,
                                 output bit emits, output slot_t slot);
        int unsigned gain;
        int          bitpos;
        logic [23:0] grb;
        emits = 1'b0;
        slot  = '0;
        grb   = {green, red, blue};
        case (req)
            REQ_SET_ONE: begin
                if (idx < LEDS) raw_grb[idx] = grb;
            end
            REQ_SET_ALL: begin
                foreach (raw_grb[i]) raw_grb[i] = grb;
            end
            REQ_APPLY: begin
                gain = angle_gain[bright_reg];
                foreach (lit_grb[i])
                    lit_grb[i] = {dim(raw_grb[i][23:16], gain), dim(raw_grb[i][15:8], gain),
                                  dim(raw_grb[i][7:0], gain)};
            end
            default: begin
                emits = 1'b1;
                if (slot_pos < DATA_SLOTS) begin
                    bitpos = BITS_PER_LED - 1 - slot_pos % BITS_PER_LED;
                    slot.duty = lit_grb[slot_pos / BITS_PER_LED][bitpos] ? one_reg : zero_reg;
                end
                // frame end follows the current latch length, even mid-frame
                slot.last = (slot_pos + 1 >= DATA_SLOTS + int'(latch_reg));
                slot_pos  = slot.last ? 0 : slot_pos + 1;
            end
        endcase
    endtask

    task automatic send_word(input req_t req, input logic [3:0] idx,
                             input logic [7:0] red, green, blue,
                             output bit emits, output slot_t slot);
        int gap;
        gap = 0;
        if (idle_on)
            while ($urandom_range(0, 99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, blue, green, red, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_strip(req, idx, red, green, blue, emits, slot);
    endtask

    // Drop valid, drain every expected word, then give a brightness pass time to end.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_slots.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [7:0] bright, one, zero, latch);
        write_reg(REG_BRIGHTNESS, bright);
        write_reg(REG_ONE_DUTY, one);
        write_reg(REG_ZERO_DUTY, zero);
        write_reg(REG_LATCH_SLOTS, latch);
        cfg_wr_en  <= 1'b0;
        bright_reg = (bright[5:0] > MAX_ANGLE) ? MAX_ANGLE : bright[5:0];
        one_reg    = one;
        zero_reg   = zero;
        latch_reg  = latch;
    endtask

    // Mostly slot requests; run until the count, a slot position and a number
    // of frame ends are all reached.
    task automatic run_phase(input int count, input int pos_goal, input int wraps_goal,
                             input int slot_pct);
        int    sent;
        int    wraps;
        int    pick;
        req_t  req;
        bit    emits;
        slot_t slot;
        sent  = 0;
        wraps = 0;
        while (sent < count || slot_pos < pos_goal || wraps < wraps_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < slot_pct)
                req = REQ_SLOT;
            else if (pick < slot_pct + (100 - slot_pct) / 2)
                req = REQ_SET_ONE;
            else if ($urandom_range(0, 2) == 0)
                req = REQ_SET_ALL;
            else
                req = REQ_APPLY;
            send_word(req, 4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom),
                      8'($urandom), emits, slot);
            if (emits) begin
                pending_slots.push_back(slot);
                if (slot.last) wraps++;
            end
            sent++;
        end
    endtask

    initial begin : stimulus
        bit    emits;
        slot_t slot;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            send_word(script[i].req, script[i].idx, script[i].red, script[i].green,
                      script[i].blue, emits, slot);
            if (emits) begin
                if (script[i].typed) begin
                    slot.duty = script[i].duty;
                    slot.last = script[i].last;
                end
                pending_slots.push_back(slot);
            end
        end
        settle();

        // saturating brightness write; run into the latch region
        load_settings(8'h3F, 8'hFF, 8'h00, 8'd20);
        run_phase(60, 290, 0, 88);
        settle();

        // no latch slots: the position is already past the new end
        load_settings(8'($urandom_range(1, 44)), 8'($urandom), 8'($urandom), 8'd0);
        run_phase(40, 0, 1, 90);
        settle();

        // masked brightness bits give zero; no idling on either side
        idle_on = 1'b0;
        load_settings(8'hC0, 8'h00, 8'hFF, 8'hFF);
        run_phase(40, 0, 0, 65);
        settle();

        idle_on = 1'b1;
        load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_phase(40, 0, 0, 65);
        settle();

        if (mismatches == 0) begin
            $display("tb_ws2812_frame_encoder OK");
        end else begin
            $display("tb_ws2812_frame_encoder NOT OK");
        end
        $finish;
    end

endmodule
